/* rtl/core/kmr_pkg.sv */
// ---------------------------------------------------------------------------
// kmr_pkg: shared types and constants of the keyboard macro recorder
// Holds the field codes, register indexes, the store entry layout and the
// command and status structs between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmr_pkg;

  localparam int unsigned CODE_W    = 10;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned ENTRY_W   = CODE_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  // Input tdata: key_code, key_action, zero fill to 16 bits.
  localparam int unsigned IN_DATA_W  = 16;
  // Output tdata: pass_through, record_light, replay_code, replay_press,
  // zero fill to 16 bits.
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REPEAT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RECORD_KEY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK_KEY = 2'd1;

  localparam logic [CODE_W-1:0] RECORD_KEY_RESET   = 10'd70;
  localparam logic [CODE_W-1:0] PLAYBACK_KEY_RESET = 10'd41;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR2,
    ST_RES
  } ctrl_state_e;

  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic wr2;     // second store write of an autorepeat
    logic load;    // move the pending result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic store_two;  // the offered event is stored as release plus press
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/keyboard_macro_recorder_core.sv */
// ---------------------------------------------------------------------------
// keyboard_macro_recorder_core: key macro recorder and player
// Usage: key events and playback ticks arrive as beats on the s_axis
// channel (tuser 0 = key event, 1 = tick). Each beat yields exactly one
// result beat on m_axis: pass/consume decision and record light for key
// events, or for ticks the next replayed event while a replay runs, with
// tlast set on the tick that ends the replay.
// The record and playback key codes are written through the cfg channel,
// which is always ready; write them only while the block is idle.
// Timing: a beat is taken in the idle state; its result is registered in
// the pending registers and moved to the output register once that is
// free, and only then is a new beat taken. An autorepeat stored while
// recording adds a second write state, as the store has one write port
// and the repeat writes two entries; ticks use its registered read port.
// If the receiver stalls, the result waits in the output register and the
// next input beat is taken; its result waits until the first is taken.
// Reset clears the flags, count and replay index and restores the default
// keys; the event store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyboard_macro_recorder_core #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tdata: key_code [9:0], key_action [11:10], zero fill [15:12]
  input  wire logic [kmr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: func [0]
  input  wire logic                             s_axis_tuser,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: pass_through [0], record_light [1], replay_code [11:2],
  // replay_press [12], zero fill [15:13]
  output logic      [kmr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: replay_valid [0]
  output logic                                  m_axis_tuser,
  // tlast: replay_done
  output logic                                  m_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [kmr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [kmr_pkg::CODE_W-1:0]       cfg_data_i
);

  import kmr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  kmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kmr_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .func_i             (s_axis_tuser),
    .key_code_i         (s_axis_tdata[CODE_W-1:0]),
    .key_action_i       (s_axis_tdata[CODE_W+ACTION_W-1:CODE_W]),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_data_o         (m_axis_tdata),
    .out_replay_valid_o (m_axis_tuser),
    .out_last_o         (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* rtl/core/kmr_ram.sv */
// ---------------------------------------------------------------------------
// kmr_ram: generic simple dual port RAM
// One write port and one read port; read data is registered and holds
// its value until the next read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmr_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kmr_ctrl.sv */
// ---------------------------------------------------------------------------
// kmr_ctrl: sequencing of one item at a time
// Takes an input beat, adds a second store write for a recorded autorepeat and
// hands the result to the output register once it is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire kmr_pkg::dp_status_t status_i,
  output kmr_pkg::ctrl_cmd_t       cmd_o
);

  import kmr_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    out_free     = !out_valid_q || out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = status_i.store_two ? ST_WR2 : ST_RES;
        end
      end
      ST_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = ST_RES;
      end
      ST_RES: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q != ST_IDLE))
    else $error("controller idle right after an accepted beat");

  a_wr2_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR2) |-> $past(cmd_o.accept && status_i.store_two))
    else $error("second store write without an autorepeat");

endmodule

`default_nettype wire

/* rtl/core/kmr_datapath.sv */
// ---------------------------------------------------------------------------
// kmr_datapath: recorder state, event store and result register
// Decodes key events and ticks, updates the flags, count and replay
// index, drives the store and builds the result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmr_datapath #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire kmr_pkg::ctrl_cmd_t               cmd_i,
  output kmr_pkg::dp_status_t                   status_o,
  input  wire logic                             func_i,
  input  wire logic [kmr_pkg::CODE_W-1:0]       key_code_i,
  input  wire logic [kmr_pkg::ACTION_W-1:0]     key_action_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [kmr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [kmr_pkg::CODE_W-1:0]       cfg_data_i,
  output logic      [kmr_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                                  out_replay_valid_o,
  output logic                                  out_last_o
);

  import kmr_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] FULL_AT = AW'(STORE_DEPTH - 2);

  logic [CODE_W-1:0] rec_key_q, play_key_q;
  logic              rec_q, rec_d;
  logic              rep_q, rep_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CODE_W-1:0] code_q, code_d;

  // Pending result: pass_through, record_light, replay_valid, replay_done.
  logic p_pass_q, p_light_q, p_rv_q, p_done_q;
  logic p_pass_d, p_rv_d, p_done_d;

  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  logic is_play, is_rec, is_rel, is_rep, full;

  logic [OUT_DATA_W-1:0] out_q;
  logic                  out_rv_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_key_q  <= RECORD_KEY_RESET;
      play_key_q <= PLAYBACK_KEY_RESET;
      rec_q      <= 1'b0;
      rep_q      <= 1'b0;
      cnt_q      <= '0;
      idx_q      <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == REG_RECORD_KEY) begin
        rec_key_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == REG_PLAYBACK_KEY) begin
        play_key_q <= cfg_data_i;
      end
      rec_q <= rec_d;
      rep_q <= rep_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    if (cmd_i.accept) begin
      p_pass_q  <= p_pass_d;
      p_light_q <= rec_d;
      p_rv_q    <= p_rv_d;
      p_done_q  <= p_done_d;
    end
    if (cmd_i.load) begin
      out_rv_q   <= p_rv_q;
      out_last_q <= p_done_q;
      out_q      <= {(OUT_DATA_W - 13)'(0),
                     p_rv_q ? rdata[CODE_W] : 1'b0,
                     p_rv_q ? rdata[CODE_W-1:0] : {CODE_W{1'b0}},
                     p_light_q, p_pass_q};
    end
  end

  assign is_play = key_code_i == play_key_q;
  assign is_rec  = key_code_i == rec_key_q;
  assign is_rel  = key_action_i == ACT_RELEASE;
  assign is_rep  = key_action_i == ACT_REPEAT;
  assign full    = cnt_q >= FULL_AT;

  assign status_o.store_two = (func_i == FUNC_KEY) && rec_q && !is_play && !is_rec
                              && !full && is_rep;

  always_comb begin
    rec_d    = rec_q;
    rep_d    = rep_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    code_d   = code_q;
    p_pass_d = 1'b0;
    p_rv_d   = 1'b0;
    p_done_d = 1'b0;
    we       = 1'b0;
    waddr    = cnt_q;
    wdata    = '0;
    re       = 1'b0;
    raddr    = idx_q;
    if (cmd_i.accept) begin
      if (func_i == FUNC_TICK) begin
        if (rep_q) begin
          if (idx_q < cnt_q) begin
            re     = 1'b1;
            p_rv_d = 1'b1;
            idx_d  = idx_q + 1'b1;
            if (idx_d == cnt_q) begin
              p_done_d = 1'b1;
              rep_d    = 1'b0;
            end
          end else begin
            p_done_d = 1'b1;
            rep_d    = 1'b0;
          end
        end
      end else if (!rec_q) begin
        if (rep_q) begin
          p_pass_d = 1'b1;
        end else if (is_play) begin
          if (!is_rel) begin
            rep_d = 1'b1;
            idx_d = '0;
          end
        end else if (is_rec && is_rel) begin
          cnt_d = '0;
          rec_d = 1'b1;
        end else begin
          p_pass_d = 1'b1;
        end
      end else begin
        if (is_play) begin
          p_pass_d = 1'b0;
        end else if (is_rec) begin
          if (is_rel) begin
            rec_d = 1'b0;
          end
        end else if (full) begin
          rec_d    = 1'b0;
          p_pass_d = 1'b1;
        end else begin
          // An autorepeat goes in as a release now and a press next cycle.
          we       = 1'b1;
          wdata    = {(!is_rep && !is_rel), key_code_i};
          cnt_d    = cnt_q + 1'b1;
          code_d   = key_code_i;
          p_pass_d = 1'b1;
        end
      end
    end
    if (cmd_i.wr2) begin
      we    = 1'b1;
      wdata = {1'b1, code_q};
      cnt_d = cnt_q + 1'b1;
    end
  end

  kmr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_data_o         = out_q;
  assign out_replay_valid_o = out_rv_q;
  assign out_last_o         = out_last_q;

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rec_q && rep_q))
    else $error("recording and replaying at once");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q |-> (idx_q <= cnt_q))
    else $error("replay index beyond the event count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr2 |-> $past(status_o.store_two) && (cnt_q < AW'(STORE_DEPTH - 1)))
    else $error("second store write past the end of the store");

endmodule

`default_nettype wire

/* sim/tb_keyboard_macro_recorder_core.sv */
// ---------------------------------------------------------------------------
// tb_keyboard_macro_recorder_core: self-checking bench for the macro recorder
// A short table of hand-picked key events and ticks runs first. Random
// phases of record, replay and noise sessions follow under several key
// settings. Every result beat is compared field by field with its table value
// or with a software copy of the recorder that tracks flags, count and store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_keyboard_macro_recorder_core;
  import kmr_pkg::*;

  localparam int unsigned MACRO_DEPTH = 1024;
  localparam logic [ACTION_W-1:0] ACT_PRESS = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ODD   = 2'd3;
  localparam logic [CODE_W-1:0]   CODE_TOP  = 10'd767;

  typedef struct packed {
    logic              pass;
    logic              light;
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              press;
    logic              done;
  } macro_result_t;

  typedef struct packed {
    logic                func;
    logic [CODE_W-1:0]   code;
    logic [ACTION_W-1:0] action;
    logic                fixed;
    macro_result_t       want;
  } key_beat_t;

  localparam macro_result_t R_ZERO     = '0;
  localparam macro_result_t R_PASSED   = '{pass: 1'b1, default: '0};
  localparam macro_result_t R_REC_ON   = '{light: 1'b1, default: '0};
  localparam macro_result_t R_DONE     = '{done: 1'b1, default: '0};

  localparam logic [CODE_W-1:0] REC0  = RECORD_KEY_RESET;
  localparam logic [CODE_W-1:0] PLAY0 = PLAYBACK_KEY_RESET;

  // Rows with fixed set to 0 are checked against the software recorder.
  localparam int DIR_N = 24;
  localparam key_beat_t DIRECTED_ROWS [DIR_N] = '{
    '{FUNC_TICK, 10'd0,    ACT_RELEASE, 1'b1, R_ZERO},
    '{FUNC_KEY,  10'd5,    ACT_PRESS,   1'b1, R_PASSED},
    '{FUNC_KEY,  PLAY0,    ACT_RELEASE, 1'b1, R_ZERO},
    '{FUNC_KEY,  PLAY0,    ACT_PRESS,   1'b1, R_ZERO},
    '{FUNC_KEY,  CODE_TOP, ACT_RELEASE, 1'b1, R_PASSED},
    '{FUNC_TICK, 10'd682,  ACT_ODD,     1'b1, R_DONE},
    '{FUNC_KEY,  REC0,     ACT_PRESS,   1'b1, R_PASSED},
    '{FUNC_KEY,  REC0,     ACT_RELEASE, 1'b1, R_REC_ON},
    '{FUNC_KEY,  10'd0,    ACT_RELEASE, 1'b0, R_ZERO},
    '{FUNC_KEY,  CODE_TOP, ACT_PRESS,   1'b0, R_ZERO},
    '{FUNC_KEY,  10'd512,  ACT_REPEAT,  1'b0, R_ZERO},
    '{FUNC_KEY,  10'd341,  ACT_ODD,     1'b0, R_ZERO},
    '{FUNC_KEY,  PLAY0,    ACT_PRESS,   1'b0, R_ZERO},
    '{FUNC_KEY,  REC0,     ACT_PRESS,   1'b0, R_ZERO},
    '{FUNC_KEY,  REC0,     ACT_REPEAT,  1'b0, R_ZERO},
    '{FUNC_KEY,  REC0,     ACT_RELEASE, 1'b1, R_ZERO},
    '{FUNC_KEY,  PLAY0,    ACT_REPEAT,  1'b0, R_ZERO},
    '{FUNC_TICK, CODE_TOP, ACT_REPEAT,  1'b0, R_ZERO},
    '{FUNC_TICK, 10'd0,    ACT_RELEASE, 1'b0, R_ZERO},
    '{FUNC_TICK, 10'd341,  ACT_PRESS,   1'b0, R_ZERO},
    '{FUNC_TICK, 10'd0,    ACT_ODD,     1'b0, R_ZERO},
    '{FUNC_TICK, 10'd682,  ACT_RELEASE, 1'b0, R_ZERO},
    '{FUNC_TICK, 10'd0,    ACT_RELEASE, 1'b1, R_ZERO},
    '{FUNC_KEY,  10'd682,  ACT_PRESS,   1'b0, R_ZERO}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_RECORD_KEY;
  logic [CODE_W-1:0]     cfg_data_i    = '0;

  keyboard_macro_recorder_core #(
    .STORE_DEPTH(MACRO_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Software copy of the recorder.
  logic [CODE_W-1:0]  rec_key      = RECORD_KEY_RESET;
  logic [CODE_W-1:0]  play_key     = PLAYBACK_KEY_RESET;
  logic               recording_q  = 1'b0;
  logic               replaying_q  = 1'b0;
  logic [10:0]        stored_count = '0;
  logic [10:0]        replay_pos   = '0;
  logic [ENTRY_W-1:0] macro_mem [MACRO_DEPTH];

  key_beat_t     issued_events [$];
  macro_result_t pending_outcomes [$];
  key_beat_t     planned_beats [$];

  int mismatches     = 0;
  int beats_taken    = 0;
  int results_seen   = 0;
  int replayed_count = 0;
  int full_stops     = 0;
  int key_settings   = 1;
  int burst_left     = 0;
  int stall_phase    = 0;

  function automatic void keep_entry(logic [CODE_W-1:0] code, logic press);
    if (stored_count < MACRO_DEPTH) begin
      macro_mem[stored_count[9:0]] = {press, code};
      stored_count++;
    end
  endfunction

  function automatic macro_result_t macro_outcome(key_beat_t ev);
    macro_result_t r;
    logic [ENTRY_W-1:0] ent;
    r = '0;
    if (ev.func == FUNC_TICK) begin
      if (replaying_q) begin
        if (replay_pos < stored_count && replay_pos < MACRO_DEPTH) begin
          ent = macro_mem[replay_pos[9:0]];
          r.valid = 1'b1;
          r.code  = ent[CODE_W-1:0];
          r.press = ent[CODE_W];
          replayed_count++;
          replay_pos++;
          if (replay_pos >= stored_count) begin
            r.done      = 1'b1;
            replaying_q = 1'b0;
          end
        end else begin
          r.done      = 1'b1;
          replaying_q = 1'b0;
        end
      end
    end else if (!recording_q) begin
      if (replaying_q) begin
        r.pass = 1'b1;
      end else if (ev.code == play_key) begin
        if (ev.action != ACT_RELEASE) begin
          replaying_q = 1'b1;
          replay_pos  = '0;
        end
      end else if (ev.code == rec_key && ev.action == ACT_RELEASE) begin
        stored_count = '0;
        recording_q  = 1'b1;
      end else begin
        r.pass = 1'b1;
      end
    end else begin
      if (ev.code == play_key) begin
        r.pass = 1'b0;
      end else if (ev.code == rec_key) begin
        if (ev.action == ACT_RELEASE) recording_q = 1'b0;
      end else if (stored_count >= MACRO_DEPTH - 2) begin
        // The store is full: recording ends and the key goes on.
        recording_q = 1'b0;
        r.pass      = 1'b1;
        full_stops++;
      end else begin
        if (ev.action == ACT_REPEAT) begin
          keep_entry(ev.code, 1'b0);
          keep_entry(ev.code, 1'b1);
        end else begin
          keep_entry(ev.code, ev.action != ACT_RELEASE);
        end
        r.pass = 1'b1;
      end
    end
    r.light = recording_q;
    return r;
  endfunction

  task automatic check_field(string fname, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // Receiver: stall pattern changes with bits 9:8 of a free-running counter.
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    case (stall_phase[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_phase[2:0] < 3);
    endcase
  end

  always @(posedge clk_i) begin
    key_beat_t     ev;
    macro_result_t got;
    macro_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.pass  = m_axis_tdata[0];
        got.light = m_axis_tdata[1];
        got.code  = m_axis_tdata[11:2];
        got.press = m_axis_tdata[12];
        got.done  = m_axis_tlast;
        got.valid = m_axis_tuser;
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          $error("result beat with no expected result pending");
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("pass_through", want.pass,  got.pass);
          check_field("record_light", want.light, got.light);
          check_field("replay_valid", want.valid, got.valid);
          check_field("replay_code",  want.code,  got.code);
          check_field("replay_press", want.press, got.press);
          check_field("replay_done",  want.done,  got.done);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ev = issued_events.pop_front();
        want = macro_outcome(ev);
        pending_outcomes.push_back(ev.fixed ? ev.want : want);
        beats_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_RECORD_KEY:   rec_key = cfg_data_i;
          REG_PLAYBACK_KEY: play_key = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  task automatic drive_beat(key_beat_t ev, bit gappy);
    if (gappy && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    issued_events.push_back(ev);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.func;
    s_axis_tdata  <= {{(IN_DATA_W - ACTION_W - CODE_W){1'b0}}, ev.action, ev.code};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (issued_events.size() != 0 || pending_outcomes.size() != 0) @(posedge clk_i);
    // An autorepeat keeps the block busy with its second store write.
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_keys(logic [CODE_W-1:0] rec, logic [CODE_W-1:0] play);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_RECORD_KEY;
    cfg_data_i  <= rec;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_PLAYBACK_KEY;
    cfg_data_i  <= play;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    key_settings++;
  endtask

  function automatic key_beat_t key_item(logic f, logic [CODE_W-1:0] c, logic [1:0] a);
    key_beat_t b;
    b = '{func: f, code: c, action: a, fixed: 1'b0, want: R_ZERO};
    return b;
  endfunction

  // Builds record and replay sessions with random content, some records left
  // open, mixed with noise. approx_len is a rough guess of the stored length.
  task automatic plan_phase(int budget, bit fill, logic [CODE_W-1:0] rec,
                            logic [CODE_W-1:0] play);
    int roll;
    int n;
    int approx_len;
    int ticks;
    bit filled;
    bit short_next;
    logic [CODE_W-1:0] c;
    logic [1:0] a;
    approx_len = 0;
    filled     = 1'b0;
    short_next = 1'b0;
    planned_beats.delete();
    while (planned_beats.size() < budget) begin
      roll = $urandom_range(0, 99);
      if (fill && !filled && planned_beats.size() > 40) begin
        // Enough autorepeats to run the store into its full limit.
        planned_beats.push_back(key_item(FUNC_KEY, rec, ACT_RELEASE));
        repeat (516) begin
          planned_beats.push_back(key_item(FUNC_KEY, 10'($urandom_range(0, 767)),
                                           ACT_REPEAT));
        end
        planned_beats.push_back(key_item(FUNC_KEY, rec, ACT_RELEASE));
        filled     = 1'b1;
        short_next = 1'b1;
        approx_len = 0;
      end else if (short_next || roll < 45) begin
        short_next = 1'b0;
        planned_beats.push_back(key_item(FUNC_KEY, rec, ACT_RELEASE));
        n = $urandom_range(1, 14);
        approx_len = 0;
        repeat (n) begin
          roll = $urandom_range(0, 99);
          c = 10'($urandom_range(0, 767));
          a = $urandom_range(0, 9) < 4 ? ACT_RELEASE : ACT_PRESS;
          case ($urandom_range(0, 9))
            7, 8: a = ACT_REPEAT;
            9:    a = ACT_ODD;
            default: ;
          endcase
          if (roll < 6) begin
            c = play;
          end else if (roll < 12) begin
            c = rec;
            if (a == ACT_RELEASE) a = ACT_PRESS;
          end else begin
            approx_len += (a == ACT_REPEAT) ? 2 : 1;
          end
          planned_beats.push_back(key_item(FUNC_KEY, c, a));
        end
        if ($urandom_range(0, 9) != 0)
          planned_beats.push_back(key_item(FUNC_KEY, rec, ACT_RELEASE));
      end else if (roll < 80) begin
        planned_beats.push_back(key_item(FUNC_KEY, play,
                                         $urandom_range(0, 1) ? ACT_PRESS : ACT_REPEAT));
        ticks = approx_len + 1 + $urandom_range(0, 2);
        if ($urandom_range(0, 6) == 0) ticks = $urandom_range(1, ticks);
        repeat (ticks) begin
          if ($urandom_range(0, 9) == 0)
            planned_beats.push_back(key_item(FUNC_KEY, 10'($urandom_range(0, 767)),
                                             2'($urandom_range(0, 3))));
          planned_beats.push_back(key_item(FUNC_TICK, 10'($urandom_range(0, 767)),
                                           2'($urandom_range(0, 3))));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          roll = $urandom_range(0, 9);
          c = roll < 2 ? rec : roll < 4 ? play : 10'($urandom_range(0, 767));
          planned_beats.push_back(key_item(1'($urandom_range(0, 1)), c,
                                           2'($urandom_range(0, 3))));
        end
      end
    end
  endtask

  initial begin : limit
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : run
    logic [CODE_W-1:0] rec_set [6];
    logic [CODE_W-1:0] play_set [6];
    int                budgets [6];
    int k;
    int p;
    rec_set  = '{RECORD_KEY_RESET,   10'd0,    CODE_TOP, 10'd200, 10'd0, 10'd0};
    play_set = '{PLAYBACK_KEY_RESET, CODE_TOP, 10'd0,    10'd200, 10'd0, 10'd0};
    budgets  = '{700, 260, 260, 160, 280, 280};
    for (p = 4; p < 6; p++) begin
      rec_set[p]  = 10'($urandom_range(0, 767));
      play_set[p] = 10'($urandom_range(0, 767));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DIR_N; k++) drive_beat(DIRECTED_ROWS[k], 1'b1);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      write_keys(rec_set[p], play_set[p]);
      plan_phase(budgets[p], p == 0, rec_set[p], play_set[p]);
      // Every other phase runs the sender without gaps.
      while (planned_beats.size() != 0) drive_beat(planned_beats.pop_front(), p[0] == 1'b0);
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d input beats and %0d result beats under %0d key settings.",
             beats_taken, results_seen, key_settings);
    $display("Replayed %0d stored events; recording hit the store limit %0d times.",
             replayed_count, full_stops);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/kmr_pkg.sv
rtl/core/kmr_ram.sv
rtl/core/kmr_ctrl.sv
rtl/core/kmr_datapath.sv
rtl/core/keyboard_macro_recorder_core.sv
sim/tb_keyboard_macro_recorder_core.sv
